/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion macros; the using scope provides clk and rst_n.

// Same-cycle implication.
`define SACR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define SACR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Invariant that holds at every edge out of reset.
`define SACR_ASSERT_ALW(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

`endif

/* rtl/sacr_pkg.sv */
`timescale 1ns / 1ps

package sacr_pkg;

  localparam int WINDOW_MAX_DEF    = 16;
  localparam int HISTORY_DEPTH_DEF = 64;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;

  localparam logic [4:0] WSIZE_RST = 5'd1;
  localparam logic [7:0] CMIN_RST  = 8'd20;
  localparam logic [7:0] CMAX_RST  = 8'd90;
  localparam logic [7:0] START_RST = 8'd50;

  localparam logic signed [8:0] NO_ANSWER = -9'sd1;

  localparam logic [7:0] SCAN_MAX_INIT = 8'd0;
  localparam logic [7:0] SCAN_MIN_INIT = 8'd255;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_SET    = 2'd1,
    MODE_UNSET  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    QK_MAX = 2'd0,
    QK_MIN = 2'd1,
    QK_NTH = 2'd2,
    QK_BAD = 2'd3
  } qkind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_WSIZE = 2'd0,
    CFG_CMIN  = 2'd1,
    CFG_CMAX  = 2'd2,
    CFG_START = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/sacr_in_if.sv */
`timescale 1ns / 1ps

interface sacr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic [1:0] query_kind;
  logic [6:0] query_index;

  modport source (output valid, output mode, output value, output query_kind,
                  output query_index, input ready);
  modport sink (input valid, input mode, input value, input query_kind,
                input query_index, output ready);
endinterface

/* rtl/sacr_out_if.sv */
`timescale 1ns / 1ps

interface sacr_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        speed;
  logic              cruise_active;
  logic              set_ok;
  logic signed [8:0] history_value;
  logic [6:0]        history_count;

  modport source (output valid, output speed, output cruise_active, output set_ok,
                  output history_value, output history_count, input ready);
  modport sink (input valid, input speed, input cruise_active, input set_ok,
                input history_value, input history_count, output ready);
endinterface

/* rtl/sacr_ram.sv */
`timescale 1ns / 1ps

module sacr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/sacr_divider.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sacr_divider #(
  parameter int DVD_W = 12,
  parameter int DVS_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output logic [DVD_W-1:0]    quotient,
  output sacr_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the shifted remainder when the subtract borrows
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
      end
      quo_nxt = {quo_r[DVD_W-2:0], ~diff[DVS_W]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/speed_average_cruise_hold.sv */
`timescale 1ns / 1ps
// Channel  | Dir | Payload                                                    | Transfer
// in_ch    | in  | mode, value, query_kind, query_index                       | valid & ready
// out_ch   | out | speed, cruise_active, set_ok, history_value, history_count | valid & ready
// cfg      | in  | cfg_index, cfg_data                                        | cfg_we
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Sample tick: S_SMP, S_SOLD, S_DIVGO, S_DIV, S_DONE; the 12-bit sum is divided by the fill.
// Max/min query: one history RAM read per cycle over history_count entries.
// The result waits in the output register while the next item is taken; a
// stalled result holds the sequencer in its last state.
// Reset is synchronous, active low; both stores need no clearing pass.

`include "assert_macros.svh"

module speed_average_cruise_hold #(
  parameter int WINDOW_MAX    = sacr_pkg::WINDOW_MAX_DEF,
  parameter int HISTORY_DEPTH = sacr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sacr_in_if.sink                     in_ch,
  sacr_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [sacr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sacr_pkg::CFG_DW-1:0] cfg_data
);

  localparam int WAW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WFW   = $clog2(WINDOW_MAX + 1);
  localparam int WOW   = $clog2(2 * WINDOW_MAX + 1);
  localparam int EW    = (WFW > 5) ? WFW : 5;
  localparam int SUM_W = $clog2(WINDOW_MAX * 255 + 1);
  localparam int HAW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HFW   = $clog2(HISTORY_DEPTH + 1);
  localparam int HPW   = $clog2(2 * HISTORY_DEPTH + 1);
  localparam int CW    = (HFW > 7) ? HFW : 7;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SMP    = 11'b000_0000_0010,
    S_SOLD   = 11'b000_0000_0100,
    S_DIVGO  = 11'b000_0000_1000,
    S_DIV    = 11'b000_0001_0000,
    S_SET    = 11'b000_0010_0000,
    S_QNTH   = 11'b000_0100_0000,
    S_QNWAIT = 11'b000_1000_0000,
    S_QSCAN  = 11'b001_0000_0000,
    S_QTAIL  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  sacr_pkg::qkind_t kind_r, kind_nxt;
  logic [7:0]       value_r, value_nxt;
  logic [6:0]       idx_r, idx_nxt;

  logic [4:0] wsize_r, wsize_nxt;
  logic [7:0] cmin_r, cmin_nxt;
  logic [7:0] cmax_r, cmax_nxt;

  logic [WAW-1:0]   whead_r, whead_nxt;
  logic [WFW-1:0]   wfill_r, wfill_nxt;
  logic [SUM_W-1:0] wsum_r, wsum_nxt;

  logic [7:0]        speed_r, speed_nxt;
  logic              cruise_r, cruise_nxt;
  logic              ok_r, ok_nxt;
  logic signed [8:0] ans_r, ans_nxt;

  logic [HAW-1:0] hhead_r, hhead_nxt;
  logic [HFW-1:0] hfill_r, hfill_nxt;
  logic [HFW-1:0] scan_r, scan_nxt;
  logic           rd_pend_r, rd_pend_nxt;

  logic              o_valid_r, o_valid_nxt;
  logic              o_load;
  logic [7:0]        o_speed_r;
  logic              o_cruise_r;
  logic              o_ok_r;
  logic signed [8:0] o_ans_r;
  logic [6:0]        o_count_r;

  logic [EW-1:0]    eff_size;
  logic             drop;
  logic [WOW-1:0]   wold_sum;
  logic [WAW-1:0]   wold;
  logic [WAW-1:0]   whead_inc;
  logic [7:0]       w_rdata;
  logic             w_we;

  logic [HPW-1:0]   npos_sum;
  logic [HAW-1:0]   npos;
  logic [HAW-1:0]   h_raddr;
  logic [HAW-1:0]   hhead_inc;
  logic [7:0]       h_rdata;
  logic             h_we;
  logic             in_range;
  logic             better;

  logic                div_start;
  logic [SUM_W-1:0]    div_quo;
  sacr_pkg::div_stat_t div_stat;

  logic accept;
  sacr_pkg::mode_t  in_mode;
  sacr_pkg::qkind_t in_kind;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_mode = sacr_pkg::mode_t'(in_ch.mode);
  assign in_kind = sacr_pkg::qkind_t'(in_ch.query_kind);

  // window geometry
  always_comb begin
    if (wsize_r == 5'd0) begin
      eff_size = EW'(1);
    end else if (EW'(wsize_r) > EW'(WINDOW_MAX)) begin
      eff_size = EW'(WINDOW_MAX);
    end else begin
      eff_size = EW'(wsize_r);
    end
    drop     = (EW'(wfill_r) >= eff_size);
    wold_sum = WOW'(whead_r) + WOW'(WINDOW_MAX) - WOW'(wfill_r);
    if (wold_sum >= WOW'(WINDOW_MAX)) begin
      wold = WAW'(wold_sum - WOW'(WINDOW_MAX));
    end else begin
      wold = WAW'(wold_sum);
    end
    if (whead_r == WAW'(WINDOW_MAX - 1)) begin
      whead_inc = '0;
    end else begin
      whead_inc = whead_r + 1'b1;
    end
  end

  // history geometry
  always_comb begin
    npos_sum = HPW'(hhead_r) + HPW'(HISTORY_DEPTH) - HPW'(idx_r);
    if (npos_sum >= HPW'(HISTORY_DEPTH)) begin
      npos = HAW'(npos_sum - HPW'(HISTORY_DEPTH));
    end else begin
      npos = HAW'(npos_sum);
    end
    if (hhead_r == HAW'(HISTORY_DEPTH - 1)) begin
      hhead_inc = '0;
    end else begin
      hhead_inc = hhead_r + 1'b1;
    end
    h_raddr  = (state_r == S_QNTH) ? npos : scan_r[HAW-1:0];
    in_range = (value_r >= cmin_r) && (value_r <= cmax_r);
    if (kind_r == sacr_pkg::QK_MAX) begin
      better = (h_rdata > ans_r[7:0]);
    end else begin
      better = (h_rdata < ans_r[7:0]);
    end
  end

  assign w_we      = (state_r == S_SOLD);
  assign h_we      = (state_r == S_SET) && in_range;
  assign div_start = (state_r == S_DIVGO);
  assign o_load    = (state_r == S_DONE) && (!o_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    idx_nxt     = idx_r;
    wsize_nxt   = wsize_r;
    cmin_nxt    = cmin_r;
    cmax_nxt    = cmax_r;
    whead_nxt   = whead_r;
    wfill_nxt   = wfill_r;
    wsum_nxt    = wsum_r;
    speed_nxt   = speed_r;
    cruise_nxt  = cruise_r;
    ok_nxt      = ok_r;
    ans_nxt     = ans_r;
    hhead_nxt   = hhead_r;
    hfill_nxt   = hfill_r;
    scan_nxt    = scan_r;
    rd_pend_nxt = (state_r == S_QSCAN);

    // fold in the scan read issued last cycle
    if (rd_pend_r && better) begin
      ans_nxt = $signed({1'b0, h_rdata});
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          value_nxt = in_ch.value;
          idx_nxt   = in_ch.query_index;
          ok_nxt    = 1'b0;
          ans_nxt   = sacr_pkg::NO_ANSWER;
          case (in_mode)
            sacr_pkg::MODE_SAMPLE: begin
              state_nxt = cruise_r ? S_DONE : S_SMP;
            end
            sacr_pkg::MODE_SET: begin
              state_nxt = S_SET;
            end
            sacr_pkg::MODE_UNSET: begin
              cruise_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
            sacr_pkg::MODE_QUERY: begin
              if (hfill_r == '0 || in_kind == sacr_pkg::QK_BAD) begin
                state_nxt = S_DONE;
              end else if (in_kind == sacr_pkg::QK_NTH) begin
                if (in_ch.query_index == 7'd0 ||
                    CW'(in_ch.query_index) > CW'(hfill_r)) begin
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_QNTH;
                end
              end else begin
                ans_nxt   = (in_kind == sacr_pkg::QK_MAX) ?
                            $signed({1'b0, sacr_pkg::SCAN_MAX_INIT}) :
                            $signed({1'b0, sacr_pkg::SCAN_MIN_INIT});
                scan_nxt  = '0;
                state_nxt = S_QSCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SMP: begin
        state_nxt = S_SOLD;
      end
      S_SOLD: begin
        // old entry is on the read port now
        if (drop) begin
          wsum_nxt  = wsum_r - SUM_W'(w_rdata) + SUM_W'(value_r);
          wfill_nxt = wfill_r;
        end else begin
          wsum_nxt  = wsum_r + SUM_W'(value_r);
          wfill_nxt = wfill_r + 1'b1;
        end
        whead_nxt = whead_inc;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          speed_nxt = div_quo[7:0];
          state_nxt = S_DONE;
        end
      end
      S_SET: begin
        if (in_range) begin
          cruise_nxt = 1'b1;
          speed_nxt  = value_r;
          ok_nxt     = 1'b1;
          hhead_nxt  = hhead_inc;
          if (hfill_r < HFW'(HISTORY_DEPTH)) begin
            hfill_nxt = hfill_r + 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_QNTH: begin
        state_nxt = S_QNWAIT;
      end
      S_QNWAIT: begin
        ans_nxt   = $signed({1'b0, h_rdata});
        state_nxt = S_DONE;
      end
      S_QSCAN: begin
        if (scan_r == hfill_r - 1'b1) begin
          state_nxt = S_QTAIL;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_QTAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (o_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (sacr_pkg::cfg_idx_t'(cfg_index))
        sacr_pkg::CFG_WSIZE: begin
          wsize_nxt = cfg_data[4:0];
          whead_nxt = '0;
          wfill_nxt = '0;
          wsum_nxt  = '0;
        end
        sacr_pkg::CFG_CMIN: begin
          cmin_nxt = cfg_data;
        end
        sacr_pkg::CFG_CMAX: begin
          cmax_nxt = cfg_data;
        end
        sacr_pkg::CFG_START: begin
          speed_nxt = cfg_data;
        end
        default: begin
          wsize_nxt = wsize_r;
        end
      endcase
    end

    o_valid_nxt = o_valid_r && !out_ch.ready;
    if (o_load) begin
      o_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wsize_r   <= sacr_pkg::WSIZE_RST;
      cmin_r    <= sacr_pkg::CMIN_RST;
      cmax_r    <= sacr_pkg::CMAX_RST;
      whead_r   <= '0;
      wfill_r   <= '0;
      wsum_r    <= '0;
      speed_r   <= sacr_pkg::START_RST;
      cruise_r  <= 1'b0;
      hhead_r   <= '0;
      hfill_r   <= '0;
      scan_r    <= '0;
      rd_pend_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wsize_r   <= wsize_nxt;
      cmin_r    <= cmin_nxt;
      cmax_r    <= cmax_nxt;
      whead_r   <= whead_nxt;
      wfill_r   <= wfill_nxt;
      wsum_r    <= wsum_nxt;
      speed_r   <= speed_nxt;
      cruise_r  <= cruise_nxt;
      hhead_r   <= hhead_nxt;
      hfill_r   <= hfill_nxt;
      scan_r    <= scan_nxt;
      rd_pend_r <= rd_pend_nxt;
      o_valid_r <= o_valid_nxt;
    end
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    ok_r    <= ok_nxt;
    ans_r   <= ans_nxt;
    if (o_load) begin
      o_speed_r  <= speed_r;
      o_cruise_r <= cruise_r;
      o_ok_r     <= ok_r;
      o_ans_r    <= ans_r;
      o_count_r  <= 7'(hfill_r);
    end
  end

  sacr_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (8),
    .AW    (WAW)
  ) u_window_ram (
    .clk     (clk),
    .we      (w_we),
    .waddr   (whead_r),
    .wdata   (value_r),
    .raddr   (wold),
    .rdata_r (w_rdata)
  );

  sacr_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (8),
    .AW    (HAW)
  ) u_history_ram (
    .clk     (clk),
    .we      (h_we),
    .waddr   (hhead_r),
    .wdata   (value_r),
    .raddr   (h_raddr),
    .rdata_r (h_rdata)
  );

  sacr_divider #(
    .DVD_W (SUM_W),
    .DVS_W (WFW)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum_r),
    .divisor  (wfill_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // hold off input transfers while in reset
  assign in_ch.ready          = (state_r == S_IDLE) && rst_n;
  assign out_ch.valid         = o_valid_r;
  assign out_ch.speed         = o_speed_r;
  assign out_ch.cruise_active = o_cruise_r;
  assign out_ch.set_ok        = o_ok_r;
  assign out_ch.history_value = o_ans_r;
  assign out_ch.history_count = o_count_r;

  `SACR_ASSERT_IMP(a_ready_div_idle, in_ch.ready, !div_stat.busy)
  `SACR_ASSERT_NXT(a_accept_busy, accept, !in_ch.ready)
  `SACR_ASSERT_ALW(a_wfill_bound, EW'(wfill_r) <= eff_size)
  `SACR_ASSERT_ALW(a_hfill_bound, hfill_r <= HFW'(HISTORY_DEPTH))

endmodule

/* tb/speed_average_cruise_hold_test.sv */
`timescale 1ns / 1ps

module speed_average_cruise_hold_test;

  localparam int WIN_DEPTH     = sacr_pkg::WINDOW_MAX_DEF;
  localparam int HIST_DEPTH    = sacr_pkg::HISTORY_DEPTH_DEF;
  localparam int N_ROWS        = 21;
  localparam int N_PHASES      = 8;
  localparam int ITEMS_PER_SET = 240;
  localparam int HOLD_AFTER    = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct packed {
    sacr_pkg::mode_t  mode;
    logic [7:0]       value;
    sacr_pkg::qkind_t qkind;
    logic [6:0]       qidx;
  } speed_item_t;

  typedef struct packed {
    logic [7:0]        speed;
    logic              cruise;
    logic              set_ok;
    logic signed [8:0] hist_value;
    logic [6:0]        hist_count;
  } speed_report_t;

  typedef struct packed {
    speed_item_t   item;
    logic          typed;
    speed_report_t rep;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sacr_pkg::CFG_IW-1:0] cfg_index;
  logic [sacr_pkg::CFG_DW-1:0] cfg_data;

  sacr_in_if  in_bus ();
  sacr_out_if out_bus ();

  speed_average_cruise_hold u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracker state and register copies
  logic [4:0]  reg_wsize;
  logic [7:0]  reg_cmin;
  logic [7:0]  reg_cmax;
  logic [7:0]  reg_start;
  logic [7:0]  win_mem [WIN_DEPTH];
  logic [3:0]  win_head;
  logic [4:0]  win_fill;
  logic [11:0] win_sum;
  logic [7:0]  cur_speed;
  logic        cruise_on;
  logic [7:0]  hist_mem [HIST_DEPTH];
  logic [5:0]  hist_head;
  logic [6:0]  hist_fill;

  speed_report_t pending_reports [$];
  int mismatch_cnt = 0;
  int items_in = 0;
  int burst_left = 1;
  int stall_cyc = 0;
  bit rx_go;
  bit hold_off = 1'b0;

  row_t dir_rows [N_ROWS] = '{
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd50,  1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_BAD, 7'd0},   1'b1,
      '{8'd50,  1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd1},   1'b1,
      '{8'd50,  1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_SAMPLE, 8'd0,   sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd0,   1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_SAMPLE, 8'd255, sacr_pkg::QK_BAD, 7'd127}, 1'b1,
      '{8'd255, 1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_SET,    8'd19,  sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd255, 1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_SET,    8'd91,  sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd255, 1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd0}},
    '{'{sacr_pkg::MODE_SET,    8'd20,  sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd20,  1'b1, 1'b1, sacr_pkg::NO_ANSWER, 7'd1}},
    '{'{sacr_pkg::MODE_SAMPLE, 8'd100, sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd20,  1'b1, 1'b0, sacr_pkg::NO_ANSWER, 7'd1}},
    '{'{sacr_pkg::MODE_SET,    8'd90,  sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd90,  1'b1, 1'b1, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd90,  1'b1, 1'b0, 9'sd90,              7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_MIN, 7'd0},   1'b1,
      '{8'd90,  1'b1, 1'b0, 9'sd20,              7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd1},   1'b0, '0},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd2},   1'b0, '0},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd0},   1'b1,
      '{8'd90,  1'b1, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd3},   1'b1,
      '{8'd90,  1'b1, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd0,   sacr_pkg::QK_NTH, 7'd127}, 1'b1,
      '{8'd90,  1'b1, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_UNSET,  8'd0,   sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd90,  1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_SAMPLE, 8'd7,   sacr_pkg::QK_MAX, 7'd0},   1'b1,
      '{8'd7,   1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_QUERY,  8'd255, sacr_pkg::QK_BAD, 7'd127}, 1'b1,
      '{8'd7,   1'b0, 1'b0, sacr_pkg::NO_ANSWER, 7'd2}},
    '{'{sacr_pkg::MODE_SET,    8'd55,  sacr_pkg::QK_NTH, 7'd64},  1'b0, '0}
  };

  // window_size, cruise_min, cruise_max, start_speed per phase
  logic [7:0] phase_regs [N_PHASES][4] = '{
    '{8'd4,   8'd30,  8'd120, 8'd0},
    '{8'd16,  8'd0,   8'd255, 8'd255},
    '{8'd0,   8'd200, 8'd100, 8'd17},
    '{8'd255, 8'd0,   8'd0,   8'd128},
    '{8'd1,   8'd255, 8'd255, 8'd90},
    '{8'd17,  8'd20,  8'd90,  8'd50},
    '{8'd7,   8'd60,  8'd180, 8'd200},
    '{8'd200, 8'd10,  8'd250, 8'd1}
  };

  function automatic void clear_window();
    win_head = '0;
    win_fill = '0;
    win_sum  = '0;
  endfunction

  function automatic void reset_tracker();
    reg_wsize = sacr_pkg::WSIZE_RST;
    reg_cmin  = sacr_pkg::CMIN_RST;
    reg_cmax  = sacr_pkg::CMAX_RST;
    reg_start = sacr_pkg::START_RST;
    clear_window();
    cur_speed = sacr_pkg::START_RST;
    cruise_on = 1'b0;
    hist_head = '0;
    hist_fill = '0;
  endfunction

  function automatic void apply_reg(sacr_pkg::cfg_idx_t idx, logic [7:0] d);
    case (idx)
      sacr_pkg::CFG_WSIZE: begin
        reg_wsize = d[4:0];
        clear_window();
      end
      sacr_pkg::CFG_CMIN: reg_cmin = d;
      sacr_pkg::CFG_CMAX: reg_cmax = d;
      default: begin
        reg_start = d;
        cur_speed = d;
      end
    endcase
  endfunction

  function automatic speed_report_t predict_report(speed_item_t it);
    speed_report_t r;
    logic [4:0] eff;
    logic [3:0] old_pos;
    logic [5:0] pos;
    logic [7:0] best;
    r.set_ok     = 1'b0;
    r.hist_value = sacr_pkg::NO_ANSWER;
    case (it.mode)
      sacr_pkg::MODE_SAMPLE: begin
        if (!cruise_on) begin
          if (reg_wsize == 0) eff = 5'd1;
          else if (reg_wsize > WIN_DEPTH) eff = 5'(WIN_DEPTH);
          else eff = reg_wsize;
          // drop the oldest sample once the window is full
          if (win_fill >= eff) begin
            old_pos = win_head - win_fill[3:0];
            win_sum -= {4'b0, win_mem[old_pos]};
            win_fill--;
          end
          win_mem[win_head] = it.value;
          win_head++;
          win_fill++;
          win_sum += {4'b0, it.value};
          cur_speed = 8'(win_sum / win_fill);
        end
      end
      sacr_pkg::MODE_SET: begin
        if (it.value >= reg_cmin && it.value <= reg_cmax) begin
          cruise_on = 1'b1;
          cur_speed = it.value;
          hist_mem[hist_head] = it.value;
          hist_head++;
          if (hist_fill < HIST_DEPTH) hist_fill++;
          r.set_ok = 1'b1;
        end
      end
      sacr_pkg::MODE_UNSET: cruise_on = 1'b0;
      default: begin
        if (hist_fill != 0 && it.qkind != sacr_pkg::QK_BAD) begin
          if (it.qkind == sacr_pkg::QK_NTH) begin
            if (it.qidx != 0 && it.qidx <= hist_fill) begin
              pos = hist_head - it.qidx[5:0];
              r.hist_value = $signed({1'b0, hist_mem[pos]});
            end
          end else begin
            best = (it.qkind == sacr_pkg::QK_MAX) ? sacr_pkg::SCAN_MAX_INIT :
                                                   sacr_pkg::SCAN_MIN_INIT;
            for (int i = 0; i < hist_fill; i++) begin
              pos = hist_head - 6'(i) - 6'd1;
              if (it.qkind == sacr_pkg::QK_MAX ? hist_mem[pos] > best :
                                                 hist_mem[pos] < best)
                best = hist_mem[pos];
            end
            r.hist_value = $signed({1'b0, best});
          end
        end
      end
    endcase
    r.speed      = cur_speed;
    r.cruise     = cruise_on;
    r.hist_count = hist_fill;
    return r;
  endfunction

  function automatic speed_item_t random_item();
    speed_item_t it;
    int pick;
    it.value = 8'($urandom_range(0, 255));
    it.qkind = sacr_pkg::qkind_t'(2'($urandom_range(0, 3)));
    it.qidx  = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.mode = sacr_pkg::MODE_SAMPLE;
    end else if (pick < 62) begin
      it.mode = sacr_pkg::MODE_SET;
      // mostly aim inside the accepted range so the history fills and wraps
      if (reg_cmin <= reg_cmax && $urandom_range(0, 3) != 0)
        it.value = 8'($urandom_range(reg_cmax, reg_cmin));
    end else if (pick < 75) begin
      it.mode = sacr_pkg::MODE_UNSET;
    end else begin
      it.mode = sacr_pkg::MODE_QUERY;
      if ($urandom_range(0, 9) < 7) it.qidx = 7'($urandom_range(0, hist_fill + 1));
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_report();
    speed_report_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch("result with nothing pending, speed", out_bus.speed, -1);
      return;
    end
    want = pending_reports.pop_front();
    if (out_bus.speed !== want.speed)
      flag_mismatch("speed", out_bus.speed, want.speed);
    if (out_bus.cruise_active !== want.cruise)
      flag_mismatch("cruise_active", out_bus.cruise_active, want.cruise);
    if (out_bus.set_ok !== want.set_ok)
      flag_mismatch("set_ok", out_bus.set_ok, want.set_ok);
    if (out_bus.history_value !== want.hist_value)
      flag_mismatch("history_value", int'(out_bus.history_value), int'(want.hist_value));
    if (out_bus.history_count !== want.hist_count)
      flag_mismatch("history_count", out_bus.history_count, want.hist_count);
  endtask

  task automatic offer_item(input speed_item_t it, input logic typed,
                            input speed_report_t typed_rep);
    speed_report_t r;
    int gap;
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= it.mode;
    in_bus.value       <= it.value;
    in_bus.query_kind  <= it.qkind;
    in_bus.query_index <= it.qidx;
    do @(posedge clk); while (!in_bus.ready);
    r = predict_report(it);
    if (typed) r = typed_rep;
    pending_reports = {pending_reports, r};
    items_in++;
    // end of burst: idle for a random gap, or run straight on
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input int ph);
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= sacr_pkg::cfg_idx_t'(k);
      cfg_data  <= phase_regs[ph][k];
      @(posedge clk);
      apply_reg(sacr_pkg::cfg_idx_t'(k), phase_regs[ph][k]);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_report();
      stall_cyc++;
      case ((stall_cyc / 256) % 4)
        0: rx_go = 1'b1;
        1: rx_go = ($urandom_range(0, 9) < 7);
        2: rx_go = ((stall_cyc % 6) >= 2);
        default: rx_go = ($urandom_range(0, 9) < 3);
      endcase
      out_bus.ready <= rx_go && !hold_off;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (items_in < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("speed_average_cruise_hold: mismatch");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.mode        <= sacr_pkg::MODE_SAMPLE;
    in_bus.value       <= '0;
    in_bus.query_kind  <= sacr_pkg::QK_MAX;
    in_bus.query_index <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= sacr_pkg::CFG_WSIZE;
    cfg_data           <= '0;
    reset_tracker();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < N_ROWS; n++)
      offer_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].rep);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      load_settings(ph);
      for (int n = 0; n < ITEMS_PER_SET; n++)
        offer_item(random_item(), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_reports.size() == 0)
      $display("speed_average_cruise_hold: match");
    else
      $display("speed_average_cruise_hold: mismatch");
    $finish;
  end

endmodule
